### design/mtsba_pkg.sv
package mtsba_pkg;

	// result status codes
	typedef enum logic [2:0] {
		ST_ALLOC     = 3'd0,
		ST_DEFINED   = 3'd1,
		ST_NO_TYPE   = 3'd2,
		ST_FULL      = 3'd3,
		ST_TOO_LARGE = 3'd4
	} status_t;

	// sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_REQ,
		S_DES,
		S_HEAP,
		S_POOL,
		S_DECIDE,
		S_DIV,
		S_PAD,
		S_WB,
		S_DONE
	} state_t;

	localparam int unsigned AW48 = 48;
	localparam logic [AW48-1:0] MAX48 = {AW48{1'b1}};
	localparam logic [AW48-1:0] POOL_SIZE_RST = 48'd268435456;

	// saturate a 49-bit sum to 48 bits
	function automatic logic [AW48-1:0] sat48(input logic [AW48:0] v);
		sat48 = v[AW48] ? MAX48 : v[AW48-1:0];
	endfunction

endpackage

### design/memory_type_select_pool_bump_allocator_unit.sv
// Memory type selector with per-type bump pools. A define transaction loads one
// type entry and returns status 1. An allocate transaction is handled one at a
// time by a sequencer: the required-flag mask, one narrowing step per desired
// flag set (up to 3), a scan of the heap-size memory for the largest eligible
// heap, a scan of the pool memory (one entry per cycle on its single read port),
// a bit-serial remainder for the alignment, and then the decision, padding,
// write-back and the result. Early exits (no suitable type, too large, pools
// full) skip the later steps. No clearing pass is needed after reset: pool
// entries are only read below the open count.
module memory_type_select_pool_bump_allocator_unit
	import mtsba_pkg::*;
#(
	parameter int unsigned NUM_TYPES      = 32,
	parameter int unsigned POOLS_PER_TYPE = 8,
	parameter int unsigned MAX_DESIRED    = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	// apb configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [4:0]  entry_index,
	input  logic [8:0]  entry_flags,
	input  logic [47:0] entry_heap_size,
	input  logic [47:0] alloc_size,
	input  logic [16:0] alloc_alignment,
	input  logic [31:0] type_filter,
	input  logic [8:0]  required_flags,
	input  logic [8:0]  desired_flags_a,
	input  logic [8:0]  desired_flags_b,
	input  logic [8:0]  desired_flags_c,
	input  logic [1:0]  desired_count,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [4:0]  chosen_type,
	output logic [31:0] suitable_mask,
	output logic [2:0]  pool_slot,
	output logic        opened_pool,
	output logic [47:0] alloc_offset
);

	localparam int unsigned TW = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
	localparam int unsigned CW = $clog2(NUM_TYPES + 1);
	localparam int unsigned SW = (POOLS_PER_TYPE > 1) ? $clog2(POOLS_PER_TYPE) : 1;
	localparam int unsigned PW = $clog2(POOLS_PER_TYPE + 1);
	localparam int unsigned NPOOL = NUM_TYPES * POOLS_PER_TYPE;
	localparam int unsigned AW = (NPOOL > 1) ? $clog2(NPOOL) : 1;
	localparam int unsigned DW = $clog2(MAX_DESIRED + 1);

	state_t state_q, state_d;

	// configuration register
	logic [47:0] pool_size_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & ~paddr[3];
	assign prdata = paddr[3] ? 64'd0 : {16'd0, pool_size_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_size_q <= POOL_SIZE_RST;
		end else if (cfg_wr) begin
			pool_size_q <= pwdata[47:0];
		end
	end

	// type flag table in flops, cleared at reset
	logic [8:0]    flags_q [NUM_TYPES];
	logic [PW-1:0] open_cnt_q [NUM_TYPES];

	// captured request
	logic [47:0]          size_q;
	logic [16:0]          align_q;
	logic [NUM_TYPES-1:0] filter_q;
	logic [8:0]           reqf_q;
	logic [8:0]           des_q [3];
	logic [DW-1:0]        dcnt_q;
	logic [DW-1:0]        d_q;

	logic [NUM_TYPES-1:0] req_mask_q, suit_q;

	// heap scan
	logic [CW-1:0] hc_q;
	logic          h_vld_s1;
	logic [TW-1:0] h_idx_s1;
	logic [47:0]   best_heap_q;
	logic [TW-1:0] best_q;
	logic          bfound_q;

	// pool scan
	logic [PW-1:0] pc_q;
	logic          p_vld_s1;
	logic [SW-1:0] p_idx_s1;
	logic          pfound_q;
	logic [SW-1:0] slot_q;
	logic [47:0]   fill_q, cap_q;
	logic [AW-1:0] base_q;
	logic          opened_q;

	// remainder unit
	logic [5:0]  dc_q;
	logic [47:0] sh_q;
	logic [16:0] rem_q;
	logic [47:0] aligned_q;

	// result staging and output registers
	status_t              res_status_q;
	logic                 out_valid_q;
	logic [2:0]           status_q;
	logic [4:0]           chosen_q;
	logic [31:0]          smask_q;
	logic [2:0]           pslot_q;
	logic                 opened_out_q;
	logic [47:0]          offset_q;

	// memories
	logic          heap_we;
	logic [TW-1:0] heap_waddr, heap_raddr;
	logic [47:0]   heap_rdata;
	logic          pool_we;
	logic [AW-1:0] pool_waddr, pool_raddr;
	logic [95:0]   pool_wdata, pool_rdata;

	logic          accept, is_define, idx_ok;
	logic [PW-1:0] cnt_cur;
	logic [47:0]   r_fill, r_cap, r_free;
	logic          r_fit;
	logic [17:0]   div_t;
	logic [16:0]   align_eff, pad;
	logic [47:0]   new_fill;
	logic          last_des;

	function automatic logic [NUM_TYPES-1:0] types_with(input logic [8:0] f);
		logic [NUM_TYPES-1:0] m;
		for (int i = 0; i < NUM_TYPES; i++) begin
			m[i] = filter_q[i] && (flags_q[i] != 9'd0) && ((flags_q[i] & f) == f);
		end
		types_with = m;
	endfunction

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid & in_ready;
	assign is_define = ~req_type;
	assign idx_ok    = ({1'b0, entry_index} < 6'(NUM_TYPES));
	assign cnt_cur   = open_cnt_q[best_q];
	assign last_des  = (d_q >= dcnt_q);

	// heap memory: written by define, scanned by allocate
	assign heap_we    = accept & is_define & idx_ok;
	assign heap_waddr = TW'(entry_index);
	assign heap_raddr = hc_q[TW-1:0];

	mtsba_ram #(.WIDTH(48), .DEPTH(NUM_TYPES)) u_heap_ram (
		.clk   (clk),
		.we    (heap_we),
		.waddr (heap_waddr),
		.wdata (entry_heap_size),
		.raddr (heap_raddr),
		.rdata (heap_rdata)
	);

	// pool memory: {capacity, fill} per pool
	assign pool_raddr = base_q + AW'(pc_q[SW-1:0]);
	assign pool_waddr = base_q + AW'(slot_q);
	assign pool_we    = (state_q == S_WB);
	assign pool_wdata = {cap_q, new_fill};

	mtsba_ram #(.WIDTH(96), .DEPTH(NPOOL)) u_pool_ram (
		.clk   (clk),
		.we    (pool_we),
		.waddr (pool_waddr),
		.wdata (pool_wdata),
		.raddr (pool_raddr),
		.rdata (pool_rdata)
	);

	// free-space test on the pool read data
	assign r_fill = pool_rdata[47:0];
	assign r_cap  = pool_rdata[95:48];
	assign r_free = (r_fill >= r_cap) ? 48'd0 : (r_cap - r_fill);
	assign r_fit  = (r_free >= size_q);

	// remainder step and padding
	assign align_eff = (align_q == 17'd0) ? 17'd1 : align_q;
	assign div_t     = {rem_q, sh_q[47]};
	assign pad       = (rem_q == 17'd0) ? 17'd0 : (align_eff - rem_q);
	assign new_fill  = sat48({1'b0, aligned_q} + {1'b0, size_q});

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = is_define ? S_DONE : S_REQ;
				end
			end
			S_REQ: state_d = S_DES;
			S_DES: begin
				if (last_des) begin
					state_d = (suit_q == '0) ? S_DONE : S_HEAP;
				end
			end
			S_HEAP: begin
				if (hc_q == CW'(NUM_TYPES) && !h_vld_s1) begin
					state_d = S_POOL;
				end
			end
			S_POOL: begin
				if (!p_vld_s1 && (pfound_q || pc_q >= cnt_cur)) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (pfound_q) begin
					state_d = S_DIV;
				end else if (size_q > pool_size_q) begin
					state_d = S_DONE;
				end else if (cnt_cur >= PW'(POOLS_PER_TYPE)) begin
					state_d = S_DONE;
				end else begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (dc_q == 6'd47) begin
					state_d = S_PAD;
				end
			end
			S_PAD: state_d = S_WB;
			S_WB: state_d = S_DONE;
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// type flags and open counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TYPES; i++) begin
				flags_q[i]    <= 9'd0;
				open_cnt_q[i] <= '0;
			end
		end else begin
			if (heap_we) begin
				flags_q[heap_waddr] <= entry_flags;
			end
			if (state_q == S_DECIDE && !pfound_q && size_q <= pool_size_q
					&& cnt_cur < PW'(POOLS_PER_TYPE)) begin
				open_cnt_q[best_q] <= cnt_cur + PW'(1);
			end
		end
	end

	// scan pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_vld_s1 <= 1'b0;
			p_vld_s1 <= 1'b0;
		end else begin
			h_vld_s1 <= (state_q == S_HEAP) && (hc_q < CW'(NUM_TYPES));
			p_vld_s1 <= (state_q == S_POOL) && !pfound_q && (pc_q < cnt_cur);
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		h_idx_s1 <= hc_q[TW-1:0];
		p_idx_s1 <= pc_q[SW-1:0];
		case (state_q)
			S_IDLE: begin
				size_q   <= alloc_size;
				align_q  <= alloc_alignment;
				filter_q <= type_filter[NUM_TYPES-1:0];
				reqf_q   <= required_flags;
				des_q[0] <= desired_flags_a;
				des_q[1] <= desired_flags_b;
				des_q[2] <= desired_flags_c;
				dcnt_q   <= ({1'b0, desired_count} > 3'(MAX_DESIRED)) ? DW'(MAX_DESIRED)
				                                                    : DW'(desired_count);
				d_q          <= '0;
				res_status_q <= ST_DEFINED;
				req_mask_q   <= '0;
				suit_q       <= '0;
				best_q       <= '0;
				opened_q     <= 1'b0;
				slot_q       <= '0;
				aligned_q    <= '0;
			end
			S_REQ: begin
				req_mask_q <= types_with(reqf_q);
				suit_q     <= types_with(reqf_q);
			end
			S_DES: begin
				// narrow by one desired set a cycle
				if (!last_des) begin
					if ((suit_q & types_with(des_q[d_q]) & req_mask_q) != '0) begin
						suit_q <= suit_q & types_with(des_q[d_q]) & req_mask_q;
					end
					d_q <= d_q + DW'(1);
				end else begin
					res_status_q <= ST_NO_TYPE;
				end
				hc_q     <= '0;
				bfound_q <= 1'b0;
			end
			S_HEAP: begin
				// largest heap, lowest index on ties
				if (hc_q < CW'(NUM_TYPES)) begin
					hc_q <= hc_q + CW'(1);
				end
				pc_q     <= '0;
				pfound_q <= 1'b0;
				if (h_vld_s1 && suit_q[h_idx_s1] && (!bfound_q || heap_rdata > best_heap_q)) begin
					best_q      <= h_idx_s1;
					best_heap_q <= heap_rdata;
					bfound_q    <= 1'b1;
					base_q      <= AW'(h_idx_s1) * AW'(POOLS_PER_TYPE);
				end else begin
					base_q <= AW'(best_q) * AW'(POOLS_PER_TYPE);
				end
			end
			S_POOL: begin
				// first pool with room for the request
				if (!pfound_q && pc_q < cnt_cur) begin
					pc_q <= pc_q + PW'(1);
				end
				if (p_vld_s1 && !pfound_q && r_fit) begin
					pfound_q <= 1'b1;
					slot_q   <= p_idx_s1;
					fill_q   <= r_fill;
					cap_q    <= r_cap;
				end
			end
			S_DECIDE: begin
				if (!pfound_q) begin
					if (size_q > pool_size_q) begin
						res_status_q <= ST_TOO_LARGE;
					end else if (cnt_cur >= PW'(POOLS_PER_TYPE)) begin
						res_status_q <= ST_FULL;
					end else begin
						res_status_q <= ST_ALLOC;
						slot_q       <= SW'(cnt_cur);
						fill_q       <= 48'd0;
						cap_q        <= pool_size_q;
						opened_q     <= 1'b1;
						sh_q         <= 48'd0;
					end
				end else begin
					res_status_q <= ST_ALLOC;
					sh_q         <= fill_q;
				end
				dc_q  <= 6'd0;
				rem_q <= 17'd0;
			end
			S_DIV: begin
				// one remainder bit a cycle
				rem_q <= (div_t >= {1'b0, align_eff}) ? 17'(div_t - {1'b0, align_eff})
				                                      : div_t[16:0];
				sh_q  <= {sh_q[46:0], 1'b0};
				dc_q  <= dc_q + 6'd1;
			end
			S_PAD: begin
				aligned_q <= sat48({1'b0, fill_q} + 49'(pad));
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			status_q <= res_status_q;
			if (res_status_q == ST_DEFINED || res_status_q == ST_NO_TYPE) begin
				chosen_q <= 5'd0;
				smask_q  <= 32'd0;
			end else begin
				chosen_q <= 5'(best_q);
				smask_q  <= 32'(suit_q);
			end
			if (res_status_q == ST_ALLOC) begin
				pslot_q      <= 3'(slot_q);
				opened_out_q <= opened_q;
				offset_q     <= aligned_q;
			end else begin
				pslot_q      <= 3'd0;
				opened_out_q <= 1'b0;
				offset_q     <= 48'd0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign chosen_type   = chosen_q;
	assign suitable_mask = smask_q;
	assign pool_slot     = pslot_q;
	assign opened_pool   = opened_out_q;
	assign alloc_offset  = offset_q;

	// checks
	a_alloc_in_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_ALLOC |-> suitable_mask[chosen_type])
		else $error("allocated type not in suitable mask");

	a_no_type_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_NO_TYPE |-> suitable_mask == 32'd0)
		else $error("no-type result with nonempty mask");

	a_open_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_ALLOC && opened_pool |-> alloc_offset == 48'd0)
		else $error("new pool allocation not at offset zero");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_POOL |-> cnt_cur <= PW'(POOLS_PER_TYPE))
		else $error("pool open count beyond limit");

endmodule

### design/mtsba_ram.sv
module mtsba_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
